>>> rtl/hvn_pkg.sv
package hvn_pkg;

    // Fixed field widths
    localparam int HEIGHT_W = 16;
    localparam int IDX_W    = 15;
    localparam int GW_W     = 6;
    localparam int GD_W     = 11;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Arithmetic widths: vertex sums are Q3.14 in 18 bits, normals Q1.14 in 16
    localparam int COMP_W  = 18;
    localparam int NRM_W   = 16;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int LEN_W   = SQ_W;
    localparam int QB      = 15;
    localparam int T_SHIFT = 2 * QB;
    localparam int ACC_W   = 70;

    localparam int ONE_Q14 = 16384;
    localparam int Y_UNIT  = 256;

    // Register map
    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_DEPTH = 1'b1;
    localparam logic [GW_W-1:0] GRID_WIDTH_RST = 6'd30;
    localparam logic [GD_W-1:0] GRID_DEPTH_RST = 11'd30;

    // Vector component select
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } t_vec3;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_nrm3;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SQ,
        NS_INIT,
        NS_STEP,
        NS_TEST,
        NS_DONE
    } t_nrm_state;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_TRI,
        SQ_TRI_WAIT,
        SQ_ACC_RD,
        SQ_ACC_WR,
        SQ_EMIT_RD,
        SQ_EMIT_NRM,
        SQ_EMIT_WAIT,
        SQ_EMIT_OUT,
        SQ_FINISH
    } t_seq_state;

    typedef enum logic [1:0] {
        EP_FIRST,
        EP_SECOND,
        EP_ROW
    } t_emit_phase;

endpackage

>>> rtl/heightfield_vertex_normals.sv
// Channel   Dir  Handshake               Payload
// config    in   psel/penable/pready     paddr, pwdata, prdata (grid_width, grid_depth)
// height    in   i_in_valid/o_in_ready   i_height (Q8.8)
// normal    out  o_out_valid/i_out_ready o_vertex_index, o_normal_x/y/z, o_last_normal
//
// One height beat at a time. A beat on the first row or column emits nothing.
// Otherwise each normalization runs 3 squares, then a step and a test per quotient
// bit for 15 bits x 3 components, plus set-up and done; a beat runs two triangle
// normalizations plus one per emitted normal: one normal inside a row, two at
// the row end, and W+2 on the final beat.
// Synchronous active-low reset; sum valid bits clear at once, no clearing pass.
// A stalled output holds the sequencer in its emit step; input stays not ready.
module heightfield_vertex_normals #(
    parameter int MAX_WIDTH = 32,
    parameter int MAX_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hvn_pkg::APB_AW-1:0]  paddr,
    input  logic [hvn_pkg::APB_DW-1:0]  pwdata,
    output logic [hvn_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hvn_pkg::HEIGHT_W-1:0] i_height,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hvn_pkg::IDX_W-1:0]   o_vertex_index,
    output logic signed [hvn_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [hvn_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [hvn_pkg::NRM_W-1:0] o_normal_z,
    output logic                        o_last_normal
);
    import hvn_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_DEPTH);
    localparam int DW     = $clog2(MAX_DEPTH + 1);
    localparam int SDEPTH = 2 * MAX_WIDTH;
    localparam int SAW    = $clog2(SDEPTH);

    t_seq_state r_state, n_state;

    // config
    logic [GW_W-1:0] r_gw;
    logic [GD_W-1:0] r_gd;
    logic [WW-1:0] w_w;
    logic [DW-1:0] w_d;
    logic w_cfg_wr;

    // grid position of the current beat
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [IDX_W-1:0] r_idx;
    logic w_last_col, w_final, w_has_cell, w_in_acc;

    // heights: one row buffer plus the cell corners
    logic [HEIGHT_W-1:0] r_row_mem [MAX_WIDTH];
    logic [HEIGHT_W-1:0] r_h00, r_h10, r_h01, r_h11;

    // vertex sums: two rows by parity, valid bit per entry
    t_vec3 r_sum_mem [SDEPTH];
    t_vec3 r_sum_rd, w_sum_old, w_sum_new;
    logic r_svld_rd;
    logic [SDEPTH-1:0] r_svld;
    logic [CW-1:0] w_scol;
    logic w_spar;
    logic [SAW-1:0] w_saddr;
    logic w_sum_we;

    // triangle walk
    logic r_tri;
    logic [1:0] r_vk;
    logic w_vcur, w_rcur;

    // emit walk
    t_emit_phase r_ephase;
    logic [CW-1:0] r_ecol;
    logic r_epar;
    logic [IDX_W-1:0] r_eidx;
    logic r_elast;
    logic w_emit_more;

    // normalizer
    t_vec3 w_nvec;
    t_nrm3 w_nrm;
    logic w_nrm_start, w_nrm_done;

    // output register
    logic r_o_valid, r_o_last;
    logic [IDX_W-1:0] r_o_idx;
    t_nrm3 r_o_nrm;
    logic w_out_free, w_load_out;

    // ---------------- config port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[APB_AW-1] == REG_GRID_DEPTH) ? APB_DW'(r_gd) : APB_DW'(r_gw);

    // clamp to the supported grid
    always_comb begin
        if (r_gw < GW_W'(2)) begin
            w_w = WW'(2);
        end else if (int'(r_gw) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_gw);
        end
        if (r_gd < GD_W'(2)) begin
            w_d = DW'(2);
        end else if (int'(r_gd) > MAX_DEPTH) begin
            w_d = DW'(MAX_DEPTH);
        end else begin
            w_d = DW'(r_gd);
        end
    end

    assign w_last_col = (WW'(r_col) == w_w - WW'(1));
    assign w_final    = w_last_col && (DW'(r_row) == w_d - DW'(1));
    // the final beat always completes a cell, since width and depth are >= 2
    assign w_has_cell = (r_row != '0) && (r_col != '0);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ---------------- sum addressing ----------------
    // tri 0 corners: (c-1,r-1) (c,r) (c,r-1); tri 1: (c-1,r-1) (c-1,r) (c,r)
    assign w_vcur = r_tri ? (r_vk == COMP_Z) : (r_vk != COMP_X);
    assign w_rcur = r_tri ? (r_vk != COMP_X) : (r_vk == COMP_Y);

    always_comb begin
        if (r_state == SQ_EMIT_RD || r_state == SQ_EMIT_OUT) begin
            w_scol = r_ecol;
            w_spar = r_epar;
        end else begin
            w_scol = w_vcur ? r_col : r_col - CW'(1);
            w_spar = w_rcur ? r_row[0] : ~r_row[0];
        end
        w_saddr = w_spar ? SAW'(MAX_WIDTH) + SAW'(w_scol) : SAW'(w_scol);
    end

    assign w_sum_old   = r_svld_rd ? r_sum_rd : '0;
    assign w_sum_new.x = w_sum_old.x + COMP_W'(w_nrm.x);
    assign w_sum_new.y = w_sum_old.y + COMP_W'(w_nrm.y);
    assign w_sum_new.z = w_sum_old.z + COMP_W'(w_nrm.z);

    // triangle normal before scaling: (a, 1, b) with heights in Q8.8
    always_comb begin
        if (r_state == SQ_TRI) begin
            w_nvec.x = r_tri ? COMP_W'({2'b00, r_h01}) - COMP_W'({2'b00, r_h11})
                             : COMP_W'({2'b00, r_h00}) - COMP_W'({2'b00, r_h10});
            w_nvec.y = COMP_W'(Y_UNIT);
            w_nvec.z = r_tri ? COMP_W'({2'b00, r_h00}) - COMP_W'({2'b00, r_h01})
                             : COMP_W'({2'b00, r_h10}) - COMP_W'({2'b00, r_h11});
        end else begin
            w_nvec = w_sum_old;
        end
    end

    hvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_nrm_start),
        .i_vec   (w_nvec),
        .o_done  (w_nrm_done),
        .o_nrm   (w_nrm)
    );

    // ---------------- emit walk ----------------
    // first (c-1,r-1); at row end also (W-1,r-1); on the final beat the last row
    assign w_emit_more = ((r_ephase == EP_FIRST) && w_last_col)
                      || ((r_ephase != EP_ROW) && w_final)
                      || ((r_ephase == EP_ROW) && !r_elast);

    assign w_out_free = !r_o_valid || i_out_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE:      if (w_in_acc) n_state = w_has_cell ? SQ_TRI : SQ_FINISH;
            SQ_TRI:       n_state = SQ_TRI_WAIT;
            SQ_TRI_WAIT:  if (w_nrm_done) n_state = SQ_ACC_RD;
            SQ_ACC_RD:    n_state = SQ_ACC_WR;
            SQ_ACC_WR: begin
                if (r_vk == COMP_Z) begin
                    n_state = r_tri ? SQ_EMIT_RD : SQ_TRI;
                end else begin
                    n_state = SQ_ACC_RD;
                end
            end
            SQ_EMIT_RD:   n_state = SQ_EMIT_NRM;
            SQ_EMIT_NRM:  n_state = SQ_EMIT_WAIT;
            SQ_EMIT_WAIT: if (w_nrm_done) n_state = SQ_EMIT_OUT;
            SQ_EMIT_OUT:  if (w_out_free) n_state = w_emit_more ? SQ_EMIT_RD : SQ_FINISH;
            SQ_FINISH:    n_state = SQ_IDLE;
            default:      n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == SQ_IDLE);
        w_nrm_start = (r_state == SQ_TRI) || (r_state == SQ_EMIT_NRM);
        w_sum_we    = (r_state == SQ_ACC_WR);
        w_load_out  = (r_state == SQ_EMIT_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw      <= GRID_WIDTH_RST;
            r_gd      <= GRID_DEPTH_RST;
            r_col     <= '0;
            r_row     <= '0;
            r_idx     <= '0;
            r_svld    <= '0;
            r_tri     <= 1'b0;
            r_vk      <= COMP_X;
            r_ephase  <= EP_FIRST;
            r_o_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                SQ_IDLE: begin
                    if (w_in_acc) begin
                        r_tri <= 1'b0;
                        r_vk  <= COMP_X;
                    end
                end
                SQ_ACC_WR: begin
                    r_svld[w_saddr] <= 1'b1;
                    if (r_vk == COMP_Z) begin
                        r_vk     <= COMP_X;
                        r_tri    <= 1'b1;
                        r_ephase <= EP_FIRST;
                    end else begin
                        r_vk <= r_vk + 2'd1;
                    end
                end
                SQ_EMIT_OUT: begin
                    if (w_out_free) begin
                        r_svld[w_saddr] <= 1'b0;
                        if ((r_ephase == EP_FIRST) && w_last_col) begin
                            r_ephase <= EP_SECOND;
                        end else if ((r_ephase != EP_ROW) && w_final) begin
                            r_ephase <= EP_ROW;
                        end
                    end
                end
                SQ_FINISH: begin
                    if (w_final) begin
                        r_col  <= '0;
                        r_row  <= '0;
                        r_idx  <= '0;
                        r_svld <= '0;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (w_last_col) begin
                            r_col <= '0;
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                default: ;
            endcase

            // any register write restarts the grid
            if (w_cfg_wr) begin
                if (paddr[APB_AW-1] == REG_GRID_DEPTH) begin
                    r_gd <= pwdata[GD_W-1:0];
                end else begin
                    r_gw <= pwdata[GW_W-1:0];
                end
                r_col  <= '0;
                r_row  <= '0;
                r_idx  <= '0;
                r_svld <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_row_mem[r_col] <= i_height;
            r_h10            <= r_row_mem[r_col];
            r_h11            <= i_height;
        end

        if (w_sum_we) begin
            r_sum_mem[w_saddr] <= w_sum_new;
        end
        r_sum_rd  <= r_sum_mem[w_saddr];
        r_svld_rd <= r_svld[w_saddr];

        case (r_state)
            SQ_ACC_WR: begin
                if (r_vk == COMP_Z && r_tri) begin
                    r_ecol  <= r_col - CW'(1);
                    r_epar  <= ~r_row[0];
                    r_eidx  <= r_idx - IDX_W'(w_w) - IDX_W'(1);
                    r_elast <= 1'b0;
                end
            end
            SQ_EMIT_OUT: begin
                if (w_out_free) begin
                    r_o_idx <= r_eidx;
                    r_o_nrm <= w_nrm;
                    r_o_last <= r_elast;
                    if ((r_ephase == EP_FIRST) && w_last_col) begin
                        r_ecol <= r_col;
                        r_eidx <= r_eidx + IDX_W'(1);
                    end else if ((r_ephase != EP_ROW) && w_final) begin
                        r_ecol  <= '0;
                        r_epar  <= r_row[0];
                        r_eidx  <= r_idx - IDX_W'(w_w) + IDX_W'(1);
                        r_elast <= 1'b0;
                    end else begin
                        r_ecol  <= r_ecol + CW'(1);
                        r_eidx  <= r_eidx + IDX_W'(1);
                        r_elast <= (WW'(r_ecol) + WW'(2) == w_w);
                    end
                end
            end
            SQ_FINISH: begin
                r_h00 <= r_h10;
                r_h01 <= r_h11;
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_o_valid;
    assign o_vertex_index = r_o_idx;
    assign o_normal_x     = r_o_nrm.x;
    assign o_normal_y     = r_o_nrm.y;
    assign o_normal_z     = r_o_nrm.z;
    assign o_last_normal  = r_o_last;

    // ---------------- assertions ----------------
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> o_out_valid)
        else $error("emitted normal not presented");

    a_nrm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_nrm_done |-> (r_state == SQ_TRI_WAIT || r_state == SQ_EMIT_WAIT))
        else $error("normalizer finished outside a wait step");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_col == '0 && r_row == '0 && r_idx == '0 && r_svld == '0))
        else $error("register write did not restart the grid");

    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("sequencer did not take the height beat");

endmodule

>>> rtl/hvn_norm.sv
// Shared normalizer: three squares through one multiplier, then per component
// a greedy search for the largest q with (2q-1)^2 * len2 <= c^2 * 2^30,
// one quotient bit per step and test state pair, using shift/add updates only.
module hvn_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hvn_pkg::t_vec3 i_vec,
    output logic           o_done,
    output hvn_pkg::t_nrm3 o_nrm
);
    import hvn_pkg::*;

    localparam int BIT_W = $clog2(QB);

    t_nrm_state r_state, n_state;
    t_vec3 r_vec;
    logic [1:0] r_k;
    logic [LEN_W-1:0] r_len;
    logic [SQ_W-1:0] r_sq [3];
    logic [ACC_W-1:0] r_a, r_b, r_c, r_d, r_f, r_an, r_bn;
    logic [QB-1:0] r_q;
    logic [BIT_W-1:0] r_bit;
    t_nrm3 r_res;

    logic signed [COMP_W-1:0] w_comp;
    logic [COMP_W-1:0] w_mag;
    logic [SQ_W-1:0] w_sq;
    logic [ACC_W-1:0] w_e, w_t;
    logic w_ok;
    logic [QB-1:0] w_qn, w_qf;
    logic signed [NRM_W-1:0] w_val;

    always_comb begin
        case (r_k)
            COMP_X:  w_comp = r_vec.x;
            COMP_Y:  w_comp = r_vec.y;
            default: w_comp = r_vec.z;
        endcase
    end

    assign w_mag = w_comp[COMP_W-1] ? COMP_W'(-w_comp) : COMP_W'(w_comp);
    assign w_sq  = SQ_W'(w_mag) * SQ_W'(w_mag);

    // (u'-1)^2 * L = A' - 2B' + L, with u' the doubled candidate
    assign w_e  = r_an - (r_bn << 1) + ACC_W'(r_len);
    assign w_t  = ACC_W'(r_sq[r_k]) << T_SHIFT;
    assign w_qn = r_q | (QB'(1) << r_bit);
    assign w_ok = !r_q[QB-1] && (w_e <= w_t);
    assign w_qf = w_ok ? w_qn : r_q;
    assign w_val = w_comp[COMP_W-1] ? -$signed({1'b0, w_qf}) : $signed({1'b0, w_qf});

    always_comb begin
        n_state = r_state;
        case (r_state)
            NS_IDLE: if (i_start) n_state = NS_SQ;
            NS_SQ:   if (r_k == COMP_Z) n_state = NS_INIT;
            NS_INIT: n_state = (r_len == '0) ? NS_DONE : NS_STEP;
            NS_STEP: n_state = NS_TEST;
            NS_TEST: begin
                if (r_bit == '0) begin
                    n_state = (r_k == COMP_Z) ? NS_DONE : NS_INIT;
                end else begin
                    n_state = NS_STEP;
                end
            end
            NS_DONE: n_state = NS_IDLE;
            default: n_state = NS_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == NS_DONE);
        o_nrm  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
            r_k     <= COMP_X;
        end else begin
            r_state <= n_state;
            case (r_state)
                NS_IDLE: if (i_start) r_k <= COMP_X;
                NS_SQ:   r_k <= (r_k == COMP_Z) ? COMP_X : r_k + 2'd1;
                NS_TEST: if (r_bit == '0) r_k <= r_k + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            NS_IDLE: begin
                if (i_start) begin
                    r_vec <= i_vec;
                    r_len <= '0;
                end
            end
            NS_SQ: begin
                r_sq[r_k] <= w_sq;
                r_len     <= r_len + LEN_W'(w_sq);
            end
            NS_INIT: begin
                r_a   <= '0;
                r_b   <= '0;
                r_c   <= '0;
                r_d   <= ACC_W'(r_len) << QB;
                r_f   <= ACC_W'(r_len) << (2 * QB);
                r_q   <= '0;
                r_bit <= BIT_W'(QB - 1);
                // zero vector: default straight-up normal
                if (r_len == '0) begin
                    r_res.x <= '0;
                    r_res.y <= NRM_W'(ONE_Q14);
                    r_res.z <= '0;
                end
            end
            NS_STEP: begin
                r_an <= r_a + (r_c << 1) + r_f;
                r_bn <= r_b + r_d;
            end
            NS_TEST: begin
                if (w_ok) begin
                    r_a <= r_an;
                    r_b <= r_bn;
                    r_c <= (r_c + r_f) >> 1;
                    r_q <= w_qn;
                end else begin
                    r_c <= r_c >> 1;
                end
                r_d   <= r_d >> 1;
                r_f   <= r_f >> 2;
                r_bit <= r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    case (r_k)
                        COMP_X:  r_res.x <= w_val;
                        COMP_Y:  r_res.y <= w_val;
                        default: r_res.z <= w_val;
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule
